### hw/rtl/adhp_pkg.sv
// ----------------------------------------------------------------------------
// adhp_pkg
// shared types and constants for the ascii decimal/hex number parser
// ----------------------------------------------------------------------------
package adhp_pkg;

    localparam int CharW       = 8;
    localparam int DigitW      = 4;
    localparam int ValueW      = 32;
    localparam int DecAccW     = 34;
    localparam int SigCountW   = 4;
    localparam int PosW        = 2;

    localparam logic [CharW-1:0] CharLowA = 8'h61;  // 'a'
    localparam logic [CharW-1:0] CharLowZ = 8'h7A;  // 'z'
    localparam logic [CharW-1:0] CharZero = 8'h30;  // '0'
    localparam logic [CharW-1:0] CharNine = 8'h39;  // '9'
    localparam logic [CharW-1:0] CharA    = 8'h41;  // 'A'
    localparam logic [CharW-1:0] CharF    = 8'h46;  // 'F'
    localparam logic [CharW-1:0] CharH    = 8'h48;  // 'H'
    localparam logic [CharW-1:0] CharX    = 8'h58;  // 'X'
    localparam logic [CharW-1:0] CaseGap  = 8'h20;

    localparam logic [SigCountW-1:0] MaxHexDigits = 4'd8;
    localparam logic [SigCountW-1:0] MaxDecDigits = 4'd10;
    localparam logic [SigCountW-1:0] SigCountSat  = 4'd11;
    localparam logic [PosW-1:0]      PosSat       = 2'd3;
    localparam logic [PosW-1:0]      PrefixPos    = 2'd1;

    // hex letters map to digit = low nibble + 9
    localparam logic [DigitW-1:0] HexLetterBias = 4'd9;

    typedef struct packed {
        logic              is_dec;
        logic              is_hex_letter;
        logic              is_x;
        logic              is_h;
        logic [DigitW-1:0] digit;
    } char_info_t;

    typedef struct packed {
        logic              err;
        logic [ValueW-1:0] value;
    } parse_result_t;

endpackage

### hw/rtl/ascii_dec_hex_number_parser.sv
// ----------------------------------------------------------------------------
// ascii_dec_hex_number_parser
// streams ascii characters in and returns one parsed 32-bit number per string
// ----------------------------------------------------------------------------
// usage:
//   the slave channel carries one character per transfer in s_axis_tdata, with
//   s_axis_tlast high on the final character of a string. for each string the
//   master channel gives one transfer: m_axis_tdata holds the value, and
//   m_axis_tuser is the error flag (value is zero when it is set).
//   hex is chosen by a 0x prefix or an h suffix, decimal otherwise.
// timing:
//   one character per cycle while s_axis_tready is high. an accepted character
//   is held in the input register; the result of a last character is then
//   written to the output register, which drives m_axis_tvalid. the
//   per-character shift-add and range checks sit between those two registers.
// reset and stalls:
//   reset empties both registers and clears the parse state. while the output
//   register holds an untaken result, a further last character waits in the
//   input register and s_axis_tready drops; other characters keep flowing.
// ----------------------------------------------------------------------------
module ascii_dec_hex_number_parser
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [adhp_pkg::CharW-1:0]  s_axis_tdata,   // [7:0] char_code
    input  logic                        s_axis_tlast,   // last_char

    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [adhp_pkg::ValueW-1:0] m_axis_tdata,   // [31:0] number_value
    output logic                        m_axis_tuser    // [0] parse_error
);

    logic                       in_valid_reg, in_valid_next;
    logic [adhp_pkg::CharW-1:0] in_char_reg;
    logic                       in_last_reg;

    logic                       out_valid_reg, out_valid_next;
    adhp_pkg::parse_result_t    out_result_reg;

    logic                       out_free;
    logic                       step;
    adhp_pkg::char_info_t       info;
    adhp_pkg::parse_result_t    result;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && (!in_last_reg || out_free);
    assign s_axis_tready = !in_valid_reg || step;

    adhp_char_decode u_decode
    (
        .char_code (in_char_reg),
        .info      (info)
    );

    adhp_parse_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .last_char (in_last_reg),
        .info      (info),
        .result    (result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_axis_tready)
        begin
            in_valid_next = s_axis_tvalid;
        end

        out_valid_next = out_valid_reg;
        if (step && in_last_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_char_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (step && in_last_reg)
        begin
            out_result_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_result_reg.value;
    assign m_axis_tuser  = out_result_reg.err;

    a_err_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("error result with nonzero value");

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(in_valid_reg && in_last_reg))
        else $error("result without a last character");

    a_stall_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> in_valid_reg && in_last_reg && out_valid_reg)
        else $error("input stalled without a pending result");

    a_held_char_kept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !step |=> in_valid_reg && $stable(in_char_reg) && $stable(in_last_reg))
        else $error("waiting character lost or overwritten");

endmodule

### hw/rtl/adhp_char_decode.sv
// ----------------------------------------------------------------------------
// adhp_char_decode
// classifies one character, case-insensitive, and gives its digit value
// ----------------------------------------------------------------------------
module adhp_char_decode
(
    input  logic [adhp_pkg::CharW-1:0] char_code,
    output adhp_pkg::char_info_t       info
);

    logic [adhp_pkg::CharW-1:0] upper;

    always_comb
    begin
        if (char_code >= adhp_pkg::CharLowA && char_code <= adhp_pkg::CharLowZ)
        begin
            upper = char_code - adhp_pkg::CaseGap;
        end
        else
        begin
            upper = char_code;
        end

        info.is_dec        = (upper >= adhp_pkg::CharZero) && (upper <= adhp_pkg::CharNine);
        info.is_hex_letter = (upper >= adhp_pkg::CharA) && (upper <= adhp_pkg::CharF);
        info.is_x          = (upper == adhp_pkg::CharX);
        info.is_h          = (upper == adhp_pkg::CharH);

        if (info.is_hex_letter)
        begin
            info.digit = upper[adhp_pkg::DigitW-1:0] + adhp_pkg::HexLetterBias;
        end
        else
        begin
            info.digit = upper[adhp_pkg::DigitW-1:0];
        end
    end

endmodule

### hw/rtl/adhp_parse_core.sv
// ----------------------------------------------------------------------------
// adhp_parse_core
// per-character parse state, accumulators and final status/value check
// ----------------------------------------------------------------------------
module adhp_parse_core
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      step,
    input  logic                      last_char,
    input  adhp_pkg::char_info_t      info,
    output adhp_pkg::parse_result_t   result
);

    logic [adhp_pkg::PosW-1:0]      pos_reg,        pos_next;
    logic                           prefix_reg,     prefix_next;
    logic                           digit_seen_reg, digit_seen_next;
    logic                           letter_reg,     letter_next;
    logic                           illegal_reg,    illegal_next;
    logic [adhp_pkg::SigCountW-1:0] sig_reg,        sig_next;
    logic [adhp_pkg::ValueW-1:0]    hex_reg,        hex_next;
    logic [adhp_pkg::DecAccW-1:0]   dec_reg,        dec_next;

    logic take;
    logic prefix_take;
    logic is_hex;
    logic [adhp_pkg::PosW-1:0] pos_adv;

    always_comb
    begin
        // a closing H on the last character is a suffix, not a digit
        take        = !(last_char && info.is_h);
        prefix_take = !last_char && (pos_reg == adhp_pkg::PrefixPos) && info.is_x &&
                      digit_seen_reg && (sig_reg == '0) && !illegal_reg && !letter_reg;
        pos_adv     = (pos_reg == adhp_pkg::PosSat) ? pos_reg : pos_reg + 1'b1;

        pos_next        = pos_reg;
        prefix_next     = prefix_reg;
        digit_seen_next = digit_seen_reg;
        letter_next     = letter_reg;
        illegal_next    = illegal_reg;
        sig_next        = sig_reg;
        hex_next        = hex_reg;
        dec_next        = dec_reg;

        if (take)
        begin
            pos_next = pos_adv;
            if (prefix_take)
            begin
                prefix_next     = 1'b1;
                digit_seen_next = 1'b0;
            end
            else if (info.is_dec || info.is_hex_letter)
            begin
                letter_next     = letter_reg | info.is_hex_letter;
                digit_seen_next = 1'b1;
                // leading zeros are skipped
                if (info.digit != '0 || sig_reg != '0)
                begin
                    if (sig_reg != adhp_pkg::SigCountSat)
                    begin
                        sig_next = sig_reg + 1'b1;
                    end
                    hex_next = {hex_reg[adhp_pkg::ValueW-5:0], info.digit};
                    // times ten as x*8 + x*2, upper bits dropped
                    dec_next = {dec_reg[adhp_pkg::DecAccW-4:0], 3'b000}
                             + {dec_reg[adhp_pkg::DecAccW-2:0], 1'b0}
                             + {{(adhp_pkg::DecAccW-adhp_pkg::DigitW){1'b0}}, info.digit};
                end
            end
            else
            begin
                illegal_next = 1'b1;
            end
        end

        is_hex     = prefix_next || (last_char && info.is_h);
        result.err = illegal_next || !digit_seen_next;
        if (is_hex)
        begin
            if (sig_next > adhp_pkg::MaxHexDigits)
            begin
                result.err = 1'b1;
            end
            result.value = hex_next;
        end
        else
        begin
            if (letter_next || sig_next > adhp_pkg::MaxDecDigits ||
                dec_next[adhp_pkg::DecAccW-1:adhp_pkg::ValueW] != '0)
            begin
                result.err = 1'b1;
            end
            result.value = dec_next[adhp_pkg::ValueW-1:0];
        end
        if (result.err)
        begin
            result.value = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            prefix_reg     <= 1'b0;
            digit_seen_reg <= 1'b0;
            letter_reg     <= 1'b0;
            illegal_reg    <= 1'b0;
            sig_reg        <= '0;
            hex_reg        <= '0;
            dec_reg        <= '0;
        end
        else if (step)
        begin
            if (last_char)
            begin
                // fresh state for the next string
                pos_reg        <= '0;
                prefix_reg     <= 1'b0;
                digit_seen_reg <= 1'b0;
                letter_reg     <= 1'b0;
                illegal_reg    <= 1'b0;
                sig_reg        <= '0;
                hex_reg        <= '0;
                dec_reg        <= '0;
            end
            else
            begin
                pos_reg        <= pos_next;
                prefix_reg     <= prefix_next;
                digit_seen_reg <= digit_seen_next;
                letter_reg     <= letter_next;
                illegal_reg    <= illegal_next;
                sig_reg        <= sig_next;
                hex_reg        <= hex_next;
                dec_reg        <= dec_next;
            end
        end
    end

    a_sig_sat: assert property (@(posedge clk) disable iff (!rst_n)
        sig_reg <= adhp_pkg::SigCountSat)
        else $error("significant digit count past saturation");

    a_prefix_clears_digits: assert property (@(posedge clk) disable iff (!rst_n)
        step && prefix_take |=> prefix_reg && !digit_seen_reg && (sig_reg == '0))
        else $error("prefix taken without clearing digit state");

endmodule

### bench/adhp_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adhp_result_checker
// watches both stream channels of the number parser, predicts the status and
// value of every string from the accepted characters, and compares them in
// order with the result transfers
// ----------------------------------------------------------------------------
module adhp_result_checker
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        s_axis_tvalid,
    input  logic                        s_axis_tready,
    input  logic [adhp_pkg::CharW-1:0]  s_axis_tdata,
    input  logic                        s_axis_tlast,

    input  logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    input  logic [adhp_pkg::ValueW-1:0] m_axis_tdata,
    input  logic                        m_axis_tuser,

    output int                          fail_count,
    output int                          open_count,
    output int                          results_seen,
    output int                          error_results
);

    // parse state of the string in progress
    logic [adhp_pkg::CharW-1:0]     held_char;
    logic                           held_valid;
    logic [adhp_pkg::PosW-1:0]      seen_pos;
    logic                           prefix_taken;
    logic                           have_digit;
    logic                           saw_letter;
    logic                           saw_illegal;
    logic [adhp_pkg::SigCountW-1:0] sig_digits;
    logic [adhp_pkg::ValueW-1:0]    hex_val;
    logic [adhp_pkg::DecAccW-1:0]   dec_val;

    adhp_pkg::parse_result_t        number_q[$];

    function automatic logic [adhp_pkg::CharW-1:0] fold_case(
        input logic [adhp_pkg::CharW-1:0] c);
        if (c >= adhp_pkg::CharLowA && c <= adhp_pkg::CharLowZ)
            return c - adhp_pkg::CaseGap;
        return c;
    endfunction

    function void clear_parse();
        held_char    = '0;
        held_valid   = 1'b0;
        seen_pos     = '0;
        prefix_taken = 1'b0;
        have_digit   = 1'b0;
        saw_letter   = 1'b0;
        saw_illegal  = 1'b0;
        sig_digits   = '0;
        hex_val      = '0;
        dec_val      = '0;
    endfunction

    // one character of the number part; may_prefix when another one follows
    function void absorb_char(input logic [adhp_pkg::CharW-1:0] raw, input logic may_prefix);
        logic [adhp_pkg::CharW-1:0]  c;
        logic [adhp_pkg::DigitW-1:0] d;
        logic                        is_digit;
        c        = fold_case(raw);
        d        = '0;
        is_digit = 1'b1;
        if (may_prefix && seen_pos == adhp_pkg::PrefixPos && c == adhp_pkg::CharX &&
            have_digit && sig_digits == '0 && !saw_illegal && !saw_letter)
        begin
            prefix_taken = 1'b1;
            have_digit   = 1'b0;
            is_digit     = 1'b0;
        end
        else if (c >= adhp_pkg::CharZero && c <= adhp_pkg::CharNine)
            d = adhp_pkg::DigitW'(c - adhp_pkg::CharZero);
        else if (c >= adhp_pkg::CharA && c <= adhp_pkg::CharF)
        begin
            d          = adhp_pkg::DigitW'(c - adhp_pkg::CharA) + 4'd10;
            saw_letter = 1'b1;
        end
        else
        begin
            saw_illegal = 1'b1;
            is_digit    = 1'b0;
        end
        if (is_digit)
        begin
            have_digit = 1'b1;
            // leading zeros do not count
            if (d != '0 || sig_digits != '0)
            begin
                if (sig_digits < adhp_pkg::SigCountSat)
                    sig_digits = sig_digits + 1'b1;
                hex_val = {hex_val[adhp_pkg::ValueW-adhp_pkg::DigitW-1:0], d};
                dec_val = dec_val * 34'd10 + adhp_pkg::DecAccW'(d);
            end
        end
        if (seen_pos != adhp_pkg::PosSat)
            seen_pos = seen_pos + 1'b1;
    endfunction

    function void predict_char(input logic [adhp_pkg::CharW-1:0] c, input logic last);
        adhp_pkg::parse_result_t want;
        logic                    use_hex;
        if (held_valid)
            absorb_char(held_char, 1'b1);
        if (!last)
        begin
            held_char  = c;
            held_valid = 1'b1;
        end
        else
        begin
            use_hex = prefix_taken;
            // a closing h selects hex and is not part of the digits
            if (fold_case(c) == adhp_pkg::CharH)
                use_hex = 1'b1;
            else
                absorb_char(c, 1'b0);
            want.err = saw_illegal || !have_digit;
            if (use_hex)
            begin
                if (sig_digits > adhp_pkg::MaxHexDigits)
                    want.err = 1'b1;
                want.value = hex_val;
            end
            else
            begin
                if (saw_letter || sig_digits > adhp_pkg::MaxDecDigits ||
                    dec_val[adhp_pkg::DecAccW-1:adhp_pkg::ValueW] != '0)
                    want.err = 1'b1;
                want.value = dec_val[adhp_pkg::ValueW-1:0];
            end
            if (want.err)
                want.value = '0;
            number_q.push_back(want);
            clear_parse();
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        adhp_pkg::parse_result_t want;
        if (!rst_n)
        begin
            clear_parse();
            number_q.delete();
            open_count <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                predict_char(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (m_axis_tuser)
                    error_results++;
                if (number_q.size() == 0)
                begin
                    $error("result with no string pending: parse_error %0b, number_value 0x%08h",
                           m_axis_tuser, m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    want = number_q.pop_front();
                    if (m_axis_tuser !== want.err)
                    begin
                        $error("parse_error: expected %0b, actual %0b", want.err, m_axis_tuser);
                        fail_count++;
                    end
                    if (m_axis_tdata !== want.value)
                    begin
                        $error("number_value: expected 0x%08h, actual 0x%08h",
                               want.value, m_axis_tdata);
                        fail_count++;
                    end
                end
            end
            open_count <= number_q.size();
        end
    end

endmodule

### bench/tb_ascii_dec_hex_number_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ascii_dec_hex_number_parser
// feeds character strings to the number parser: a few fixed corner strings,
// then random decimal, 0x-prefixed and h-suffixed numbers with malformed
// strings and raw byte noise mixed in, under bursty input and a stalling
// result side; a separate checker predicts and compares every result
// ----------------------------------------------------------------------------
module tb_ascii_dec_hex_number_parser;

    localparam int NumChars   = 1650;
    localparam int CycleLimit = 400000;

    logic                        clk           = 1'b0;
    logic                        rst_n         = 1'b0;

    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [adhp_pkg::CharW-1:0]  s_axis_tdata  = '0;
    logic                        s_axis_tlast  = 1'b0;

    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [adhp_pkg::ValueW-1:0] m_axis_tdata;
    logic                        m_axis_tuser;

    int                          fail_count;
    int                          open_count;
    int                          results_seen;
    int                          error_results;

    int                          cycle_count;
    int                          chars_sent;
    int                          strings_sent;
    int                          burst_left;
    logic                        steady        = 1'b0;
    logic [adhp_pkg::CharW-1:0]  char_buf[$];

    always #6 clk = ~clk;

    ascii_dec_hex_number_parser dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    adhp_result_checker checker_i
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .open_count    (open_count),
        .results_seen  (results_seen),
        .error_results (error_results)
    );

    // run limit and result-side stall pattern
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            case (cycle_count[10:9])
                2'd0:    m_axis_tready <= 1'b1;
                2'd1:    m_axis_tready <= ($urandom_range(0, 3) != 0);
                // long regular stalls
                2'd2:    m_axis_tready <= (cycle_count[4:0] > 20);
                default: m_axis_tready <= ($urandom_range(0, 1) == 1);
            endcase
        end
    end

    function automatic logic [adhp_pkg::CharW-1:0] hex_char(input int d);
        if (d < 10)
            return adhp_pkg::CharZero + adhp_pkg::CharW'(d);
        return (($urandom_range(0, 1) != 0) ? adhp_pkg::CharA : adhp_pkg::CharLowA)
               + adhp_pkg::CharW'(d - 10);
    endfunction

    function automatic logic [adhp_pkg::CharW-1:0] dec_char();
        return adhp_pkg::CharZero + adhp_pkg::CharW'($urandom_range(0, 9));
    endfunction

    function void push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            char_buf.push_back(s[i]);
    endfunction

    function void push_hex_digits();
        int   ndig;
        logic all_f;
        all_f = ($urandom_range(0, 7) == 0);
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3)) char_buf.push_back(adhp_pkg::CharZero);
        ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 10) : $urandom_range(1, 8);
        repeat (ndig) char_buf.push_back(hex_char(all_f ? 15 : $urandom_range(0, 15)));
    endfunction

    function void build_string();
        int kind;
        int ndig;
        int spot;
        kind = $urandom_range(0, 99);
        if (kind < 30 || (kind >= 80 && kind < 85))
        begin
            // decimal, now and then right at the 32-bit limit
            if ($urandom_range(0, 5) == 0)
            begin
                push_text("429496729");
                char_buf.push_back(dec_char());
            end
            else
            begin
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 3)) char_buf.push_back(adhp_pkg::CharZero);
                ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 12)
                                                   : $urandom_range(1, 10);
                repeat (ndig) char_buf.push_back(dec_char());
            end
        end
        else if (kind < 50 || (kind >= 70 && kind < 80) || (kind >= 85 && kind < 90))
        begin
            char_buf.push_back(adhp_pkg::CharZero);
            char_buf.push_back(($urandom_range(0, 1) != 0) ? adhp_pkg::CharX
                               : (adhp_pkg::CharX | adhp_pkg::CaseGap));
            push_hex_digits();
            if (kind >= 70 && kind < 80)
                char_buf.push_back(($urandom_range(0, 1) != 0) ? adhp_pkg::CharH
                                   : (adhp_pkg::CharH | adhp_pkg::CaseGap));
        end
        else if (kind < 70)
        begin
            push_hex_digits();
            char_buf.push_back(($urandom_range(0, 1) != 0) ? adhp_pkg::CharH
                               : (adhp_pkg::CharH | adhp_pkg::CaseGap));
        end
        else
        begin
            repeat ($urandom_range(1, 6))
                char_buf.push_back(adhp_pkg::CharW'($urandom_range(0, 255)));
        end
        // broken strings: one character swapped for a random byte or a hex letter
        if (kind >= 80 && kind < 90)
        begin
            spot = $urandom_range(0, char_buf.size() - 1);
            char_buf[spot] = ($urandom_range(0, 1) != 0)
                             ? adhp_pkg::CharW'($urandom_range(0, 255))
                             : hex_char($urandom_range(10, 15));
        end
    endfunction

    task automatic send_char(input logic [adhp_pkg::CharW-1:0] c, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = steady ? 0 : $urandom_range(0, 6);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        chars_sent++;
    endtask

    task automatic send_string();
        for (int i = 0; i < char_buf.size(); i++)
            send_char(char_buf[i], i == char_buf.size() - 1);
        strings_sent++;
        char_buf.delete();
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (open_count != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corner strings: zero after prefix, lone suffix, prefix without digits,
        // decimal overflow, two-character 0x, letters with suffix, high byte, zeros
        push_text("0x0");
        send_string();
        push_text("H");
        send_string();
        push_text("0xh");
        send_string();
        push_text("4294967296");
        send_string();
        push_text("0X");
        send_string();
        push_text("ffh");
        send_string();
        char_buf.push_back(8'hFF);
        send_string();
        push_text("00");
        send_string();
        drain_results();

        while (chars_sent < NumChars)
        begin
            if (strings_sent % 12 == 0)
                steady = ($urandom_range(0, 3) == 0);
            build_string();
            send_string();
            if ($urandom_range(0, 59) == 0)
                drain_results();
        end

        drain_results();
        repeat (8) @(posedge clk);
        $display("run covered %0d characters in %0d strings: %s",
                 chars_sent, strings_sent, "decimal, 0x and h forms, limits, bad input");
        $display("%0d results compared, %0d of them flagged as parse errors",
                 results_seen, error_results);
        if (fail_count == 0 && open_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
